// File: src/rtu_pkg.sv
package rtu_pkg;

    localparam int CMD_W     = 2;
    localparam int EVENT_W   = 3;
    localparam int LENGTH_W  = 9;
    localparam int COUNT_W   = 16;

    localparam logic [CMD_W-1:0] CMD_BYTE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TAKE = 2'd2;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 3'd0,
        EV_STORED   = 3'd1,
        EV_DROPPED  = 3'd2,
        EV_ACCEPTED = 3'd3,
        EV_BAD_ADDR = 3'd4,
        EV_BAD_CRC  = 3'd5
    } event_t;

    localparam logic [15:0]        CRC_PRESET    = 16'hFFFF;
    localparam logic [15:0]        CRC_POLY      = 16'hA001;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [LENGTH_W-1:0] MIN_LEN_EXCL = 9'd3;

    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_CHAR_GAP_MAX   = 2'd1;
    localparam logic [1:0] REG_FRAME_GAP_MIN  = 2'd2;

    typedef struct packed {
        logic [7:0]         device_address;
        logic [COUNT_W-1:0] char_gap_max;
        logic [COUNT_W-1:0] frame_gap_min;
    } rtu_cfg_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int bit_idx = 0; bit_idx < 8; bit_idx++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

// File: src/rtu_apb_regs.sv
module rtu_apb_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output rtu_pkg::rtu_cfg_t cfg
);
    import rtu_pkg::*;

    rtu_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= 8'd1;
            cfg_reg.char_gap_max   <= 16'd3;
            cfg_reg.frame_gap_min  <= 16'd7;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DEVICE_ADDRESS: cfg_reg.device_address <= pwdata[7:0];
                REG_CHAR_GAP_MAX:   cfg_reg.char_gap_max   <= pwdata[15:0];
                REG_FRAME_GAP_MIN:  cfg_reg.frame_gap_min  <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DEVICE_ADDRESS: prdata = {24'd0, cfg_reg.device_address};
            REG_CHAR_GAP_MAX:   prdata = {16'd0, cfg_reg.char_gap_max};
            REG_FRAME_GAP_MIN:  prdata = {16'd0, cfg_reg.frame_gap_min};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

// File: src/rtu_frame_receiver.sv
// channel   dir  tdata                                   tuser
// s_axis    in   rx_byte[7:0]                            cmd[1:0]
// m_axis    out  byte_index, byte_value, frame_ready,    event_res[2:0], byte_valid[3]
//                frame_length[25:17], zero pad
// apb cfg   in   device_address 0x0, char_gap_max 0x4, frame_gap_min 0x8
//
// one transfer per cycle while s_tready is high: frame state updates at the input transfer and the
// result lands in the output register the same edge
// s_tready stays high while the output register is empty or being drained
// rst_n clears the frame state and the output valid flag and loads the crc preset; output data is not reset
module rtu_frame_receiver #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // rx_byte[7:0]
    input  logic [1:0]  s_tuser,    // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // byte_index[7:0], byte_value[15:8], frame_ready[16],
                                    // frame_length[25:17], zero[31:26]
    output logic [3:0]  m_tuser,    // event_res[2:0], byte_valid[3]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rtu_pkg::*;

    localparam logic [LENGTH_W-1:0] DEPTH = LENGTH_W'(BUFFER_DEPTH);

    rtu_cfg_t cfg;

    logic                in_frame_reg, in_frame_next;
    logic [LENGTH_W-1:0] byte_count_reg, byte_count_next;
    logic [COUNT_W-1:0]  gap_count_reg, gap_count_next;
    logic                gap_enable_reg, gap_enable_next;
    logic [COUNT_W-1:0]  silence_count_reg, silence_count_next;
    logic                silence_enable_reg, silence_enable_next;
    logic [15:0]         crc_reg, crc_next;
    logic [7:0]          first_byte_reg, first_byte_next;
    logic                ready_reg, ready_next;

    logic                out_valid_reg;
    logic [31:0]         out_tdata_reg;
    logic [3:0]          out_tuser_reg;

    event_t              ev;
    logic                valid;
    logic [7:0]          idx;
    logic [7:0]          val;
    logic                in_xfer;
    logic [COUNT_W-1:0]  gap_inc;
    logic [COUNT_W-1:0]  silence_inc;

    rtu_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_tuser_reg;

    assign gap_inc     = (gap_count_reg != COUNT_MAX) ? gap_count_reg + 1'b1 : gap_count_reg;
    assign silence_inc = (silence_count_reg != COUNT_MAX) ?
                         silence_count_reg + 1'b1 : silence_count_reg;

    always_comb
    begin
        in_frame_next       = in_frame_reg;
        byte_count_next     = byte_count_reg;
        gap_count_next      = gap_count_reg;
        gap_enable_next     = gap_enable_reg;
        silence_count_next  = silence_count_reg;
        silence_enable_next = silence_enable_reg;
        crc_next            = crc_reg;
        first_byte_next     = first_byte_reg;
        ready_next          = ready_reg;
        ev                  = EV_NONE;
        valid               = 1'b0;
        idx                 = 8'd0;
        val                 = 8'd0;

        case (s_tuser)
            CMD_BYTE:
            begin
                if (in_frame_reg)
                begin
                    if (gap_count_reg <= cfg.char_gap_max && byte_count_reg < DEPTH)
                    begin
                        valid               = 1'b1;
                        idx                 = byte_count_reg[7:0];
                        val                 = s_tdata;
                        byte_count_next     = byte_count_reg + 1'b1;
                        crc_next            = crc16_byte(crc_reg, s_tdata);
                        gap_enable_next     = 1'b1;
                        gap_count_next      = '0;
                        silence_enable_next = 1'b1;
                        silence_count_next  = '0;
                        ev                  = EV_STORED;
                    end
                    else
                    begin
                        // late byte or overflow drops the frame
                        in_frame_next       = 1'b0;
                        gap_enable_next     = 1'b0;
                        gap_count_next      = '0;
                        silence_enable_next = 1'b0;
                        silence_count_next  = '0;
                        ready_next          = 1'b0;
                        ev                  = EV_DROPPED;
                    end
                end
                else
                begin
                    in_frame_next       = 1'b1;
                    byte_count_next     = LENGTH_W'(1);
                    first_byte_next     = s_tdata;
                    crc_next            = crc16_byte(CRC_PRESET, s_tdata);
                    gap_enable_next     = 1'b1;
                    gap_count_next      = '0;
                    silence_enable_next = 1'b1;
                    silence_count_next  = '0;
                    ready_next          = 1'b0;
                    valid               = 1'b1;
                    val                 = s_tdata;
                    ev                  = EV_STORED;
                end
            end
            CMD_TICK:
            begin
                if (gap_enable_reg)
                begin
                    gap_count_next = gap_inc;
                    if (gap_inc > cfg.char_gap_max)
                        gap_enable_next = 1'b0;
                end
                if (silence_enable_reg)
                begin
                    silence_count_next = silence_inc;
                    if (silence_inc >= cfg.frame_gap_min)
                    begin
                        // end of frame silence, run the checks
                        silence_enable_next = 1'b0;
                        silence_count_next  = '0;
                        in_frame_next       = 1'b0;
                        if (first_byte_reg != cfg.device_address ||
                            byte_count_reg <= MIN_LEN_EXCL)
                            ev = EV_BAD_ADDR;
                        else if (crc_reg != 16'd0)
                            ev = EV_BAD_CRC;
                        else
                        begin
                            ready_next = 1'b1;
                            ev         = EV_ACCEPTED;
                        end
                    end
                end
            end
            CMD_TAKE:
            begin
                ready_next = 1'b0;
            end
            default:
            begin
                ev = EV_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg       <= 1'b0;
            byte_count_reg     <= '0;
            gap_count_reg      <= '0;
            gap_enable_reg     <= 1'b0;
            silence_count_reg  <= '0;
            silence_enable_reg <= 1'b0;
            crc_reg            <= CRC_PRESET;
            first_byte_reg     <= 8'd0;
            ready_reg          <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_frame_reg       <= in_frame_next;
            byte_count_reg     <= byte_count_next;
            gap_count_reg      <= gap_count_next;
            gap_enable_reg     <= gap_enable_next;
            silence_count_reg  <= silence_count_next;
            silence_enable_reg <= silence_enable_next;
            crc_reg            <= crc_next;
            first_byte_reg     <= first_byte_next;
            ready_reg          <= ready_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_tdata_reg <= {6'd0, byte_count_next, ready_next, val, idx};
            out_tuser_reg <= {valid, ev};
        end
    end

endmodule

// File: test/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import rtu_pkg::*;

    localparam int DEPTH = 256;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [7:0]       data;
    } rx_item_t;

    typedef struct {
        event_t               ev;
        logic                 valid;
        logic [7:0]           idx;
        logic [7:0]           val;
        logic                 ready;
        logic [LENGTH_W-1:0]  length;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // rx_byte[7:0]
    logic [1:0]  s_tuser = '0;     // cmd[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // byte_index[7:0], byte_value[15:8], frame_ready[16],
                                   // frame_length[25:17], zero[31:26]
    logic [3:0]  m_tuser;          // event_res[2:0], byte_valid[3]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rx_item_t      rx_stream[$];
    frame_result_t pending_results[$];
    int unsigned   n_queued = 0;
    int unsigned   mismatches = 0;
    int unsigned   tx_idle = 0;
    int unsigned   tx_calm = 0;
    int unsigned   rx_stall = 0;
    int unsigned   rx_calm = 0;

    // receiver state as predicted
    rtu_cfg_t             cfg = '{8'd1, 16'd3, 16'd7};
    logic                 frame_open = 1'b0;
    logic [LENGTH_W-1:0]  rx_count = '0;
    logic [COUNT_W-1:0]   gap_ticks = '0;
    logic                 gap_on = 1'b0;
    logic [COUNT_W-1:0]   quiet_ticks = '0;
    logic                 quiet_on = 1'b0;
    logic [15:0]          crc_acc = CRC_PRESET;
    logic [7:0]           lead_byte = '0;
    logic                 frame_waiting = 1'b0;

    rtu_frame_receiver #(
        .BUFFER_DEPTH(DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int k = 0; k < 8; k++)
        begin
            fb = c[0] ^ b[k];
            c = {1'b0, c[15:1]};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic int unsigned idle_len(inout int unsigned calm);
        int unsigned r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    task automatic receive_step(input logic [CMD_W-1:0] cmd, input logic [7:0] data);
        frame_result_t r;
        r = '{ev: EV_NONE, valid: 1'b0, idx: '0, val: '0, ready: 1'b0, length: '0};
        case (cmd)
            CMD_BYTE:
            begin
                if (!frame_open)
                begin
                    frame_open = 1'b1;
                    rx_count = LENGTH_W'(1);
                    lead_byte = data;
                    crc_acc = crc_step(CRC_PRESET, data);
                    gap_on = 1'b1;
                    gap_ticks = '0;
                    quiet_on = 1'b1;
                    quiet_ticks = '0;
                    frame_waiting = 1'b0;
                    r.valid = 1'b1;
                    r.val = data;
                    r.ev = EV_STORED;
                end
                else if (gap_ticks <= cfg.char_gap_max && rx_count < DEPTH)
                begin
                    r.valid = 1'b1;
                    r.idx = rx_count[7:0];
                    r.val = data;
                    rx_count++;
                    crc_acc = crc_step(crc_acc, data);
                    gap_on = 1'b1;
                    gap_ticks = '0;
                    quiet_on = 1'b1;
                    quiet_ticks = '0;
                    r.ev = EV_STORED;
                end
                else
                begin
                    // late byte or overflow
                    frame_open = 1'b0;
                    gap_on = 1'b0;
                    gap_ticks = '0;
                    quiet_on = 1'b0;
                    quiet_ticks = '0;
                    frame_waiting = 1'b0;
                    r.ev = EV_DROPPED;
                end
            end
            CMD_TICK:
            begin
                if (gap_on)
                begin
                    if (gap_ticks != COUNT_MAX)
                        gap_ticks++;
                    if (gap_ticks > cfg.char_gap_max)
                        gap_on = 1'b0;
                end
                if (quiet_on)
                begin
                    if (quiet_ticks != COUNT_MAX)
                        quiet_ticks++;
                    if (quiet_ticks >= cfg.frame_gap_min)
                    begin
                        quiet_on = 1'b0;
                        quiet_ticks = '0;
                        frame_open = 1'b0;
                        if (lead_byte != cfg.device_address || rx_count <= MIN_LEN_EXCL)
                            r.ev = EV_BAD_ADDR;
                        else if (crc_acc != 16'h0000)
                            r.ev = EV_BAD_CRC;
                        else
                        begin
                            frame_waiting = 1'b1;
                            r.ev = EV_ACCEPTED;
                        end
                    end
                end
            end
            CMD_TAKE:
                frame_waiting = 1'b0;
            default:
                ;
        endcase
        r.ready = frame_waiting;
        r.length = rx_count;
        pending_results.push_back(r);
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // input side
    always @(posedge clk)
    begin
        rx_item_t item;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (tx_idle > 0)
            begin
                tx_idle--;
                s_tvalid <= 1'b0;
            end
            else if (rx_stream.size() > 0)
            begin
                item = rx_stream.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= item.cmd;
                s_tdata <= item.data;
                tx_idle = idle_len(tx_calm);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // output side backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (rx_stall > 0)
        begin
            rx_stall--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_stall = idle_len(rx_calm);
        end
    end

    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                receive_step(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("output transfer with no result pending");
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("event_res", 16'(want.ev), 16'(m_tuser[2:0]));
                    check_field("byte_valid", 16'(want.valid), 16'(m_tuser[3]));
                    check_field("byte_index", 16'(want.idx), 16'(m_tdata[7:0]));
                    check_field("byte_value", 16'(want.val), 16'(m_tdata[15:8]));
                    check_field("frame_ready", 16'(want.ready), 16'(m_tdata[16]));
                    check_field("frame_length", 16'(want.length), 16'(m_tdata[25:17]));
                end
            end
        end
    end

    task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [7:0] data);
        rx_stream.push_back('{cmd: cmd, data: data});
        n_queued++;
    endtask

    task automatic push_ticks(input int unsigned n);
        repeat (n)
            push_item(CMD_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic push_close();
        push_ticks(cfg.frame_gap_min == 0 ? 1 : cfg.frame_gap_min);
    endtask

    // ticks that may fall between bytes without ending or breaking the frame
    function automatic int unsigned safe_spacing();
        int unsigned lim;
        if (cfg.frame_gap_min == 0)
            return 0;
        lim = cfg.char_gap_max;
        if (cfg.frame_gap_min - 1 < lim)
            lim = cfg.frame_gap_min - 1;
        return (lim > 3) ? 3 : lim;
    endfunction

    task automatic queue_frame(input logic [7:0] lead, input int unsigned len,
                               input bit crc_ok, input bit close);
        logic [7:0]  body[$];
        logic [15:0] c;
        int unsigned sp;
        int unsigned body_len;
        sp = safe_spacing();
        body_len = (crc_ok && len >= 3) ? len - 2 : len;
        body.push_back(lead);
        while (body.size() < body_len)
            body.push_back(8'($urandom_range(0, 255)));
        if (crc_ok && len >= 3)
        begin
            c = CRC_PRESET;
            foreach (body[i])
                c = crc_step(c, body[i]);
            body.push_back(c[7:0]);
            body.push_back(c[15:8]);
        end
        foreach (body[i])
        begin
            if (i > 0)
                push_ticks($urandom_range(0, sp));
            push_item(CMD_BYTE, body[i]);
        end
        if (close)
            push_close();
    endtask

    task automatic settle();
        while (rx_stream.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DEVICE_ADDRESS: cfg.device_address = value[7:0];
            REG_CHAR_GAP_MAX:   cfg.char_gap_max = value[15:0];
            REG_FRAME_GAP_MIN:  cfg.frame_gap_min = value[15:0];
            default:            ;
        endcase
    endtask

    task automatic write_cfg(input logic [7:0] addr, input logic [15:0] cgap,
                             input logic [15:0] fgap);
        write_reg(REG_DEVICE_ADDRESS, {24'd0, addr});
        write_reg(REG_CHAR_GAP_MAX, {16'd0, cgap});
        write_reg(REG_FRAME_GAP_MIN, {16'd0, fgap});
    endtask

    task automatic random_traffic(input int unsigned count);
        int unsigned mark;
        int unsigned pick;
        int unsigned len;
        int unsigned late;
        mark = n_queued;
        while (n_queued - mark < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 256)
                                                   : $urandom_range(1, 12);
                queue_frame(($urandom_range(0, 9) < 8) ? cfg.device_address
                                                       : 8'($urandom_range(0, 255)),
                            len, $urandom_range(0, 9) < 8, 1'b1);
                if ($urandom_range(0, 2) == 0)
                    push_item(CMD_TAKE, 8'($urandom_range(0, 255)));
            end
            else if (pick < 80)
            begin
                // broken sequence: byte, char_gap_max + 1 ticks (at most 8), byte
                late = (cfg.char_gap_max < 8) ? cfg.char_gap_max + 1 : 8;
                push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
                push_ticks(late);
                push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
                push_close();
            end
            else if (pick < 90)
                push_ticks($urandom_range(1, 10));
            else
                push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        logic [15:0] cgap;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: idle commands, accept, restart, late byte, short, wrong address, bad crc
        push_item(CMD_UNUSED, 8'hFF);
        push_item(CMD_TAKE, 8'h00);
        push_item(CMD_TICK, 8'hA5);
        queue_frame(cfg.device_address, 4, 1'b1, 1'b1);
        push_item(CMD_BYTE, 8'h00);
        push_ticks(4);
        push_item(CMD_BYTE, 8'hFF);
        queue_frame(cfg.device_address, 3, 1'b1, 1'b1);
        queue_frame(8'hC3, 5, 1'b1, 1'b1);
        queue_frame(cfg.device_address, 5, 1'b0, 1'b1);
        push_item(CMD_TAKE, 8'h5A);
        settle();

        // settings changed in the middle of a frame
        queue_frame(8'h5A, 6, 1'b1, 1'b0);
        settle();
        write_reg(REG_DEVICE_ADDRESS, 32'h5A);
        write_reg(REG_FRAME_GAP_MIN, 32'd2);
        push_ticks(2);
        settle();

        write_cfg(8'hFF, 16'd0, 16'd1);
        random_traffic(25);
        settle();

        // widest gap limit, full buffer, then one byte too many
        write_cfg(8'h00, 16'hFFFF, 16'd1);
        queue_frame(8'h00, DEPTH, 1'b1, 1'b0);
        push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
        push_ticks(3);
        settle();

        write_cfg(8'($urandom_range(0, 255)), 16'hFFFF, 16'd4);
        random_traffic(25);
        settle();

        write_cfg(8'($urandom_range(0, 255)), 16'd2, 16'd0);
        random_traffic(25);
        settle();

        repeat (2)
        begin
            cgap = 16'($urandom_range(0, 4));
            write_cfg(8'($urandom_range(0, 255)), cgap,
                      16'($urandom_range(cgap + 1, cgap + 6)));
            random_traffic(25);
            settle();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
